// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the quadratic root solver RTL.
// Depends on nothing; include after the clock and reset are declared.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, held off during reset.
`define QRS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: widths, pipeline depths and the
// sideband structs passed between pipeline sections. No dependencies.
`default_nettype none
package qrs_pkg;
  localparam int COEF_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int DISC_W   = 34;           // signed b*b - 4ac
  localparam int RAD_W    = 33;           // non-negative discriminant
  localparam int ROOT_W   = 33;           // floor(sqrt(disc * 2^32))
  localparam int SQ_STEPS = 33;           // one root bit per stage
  localparam int REM_W    = ROOT_W + 3;
  localparam int NB_W     = COEF_W + 1 + FRAC_W;
  localparam int NUM_W    = 35;           // signed numerator nb +/- s
  localparam int MAG_W    = NUM_W - 1;
  localparam int DEN_W    = COEF_W + 1;   // |2a|
  localparam int DIV_STEPS = MAG_W;       // one quotient bit per stage
  localparam int DREM_W   = DEN_W + 1;
  localparam int OUT_W    = 32;
  localparam int CNT_W    = 2;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic                    b_pos;
    logic signed [NB_W-1:0]  nb;
    logic                    den_neg;
    logic [DEN_W-1:0]        den_mag;
  } side_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             near_neg;
    logic             far_neg;
    logic [MAG_W-1:0] near_mag;
    logic [MAG_W-1:0] far_mag;
  } quo_t;
endpackage
`default_nettype wire

// ===== hw/rtl/qrs_front.sv =====
// Front section: coefficient products and exact discriminant, two stages.
// Depends on qrs_pkg.
`default_nettype none
module qrs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_c,
  output logic                           out_vld,
  output logic [qrs_pkg::RAD_W-1:0]      out_rad,
  output qrs_pkg::side_t                 out_side
);
  import qrs_pkg::*;

  logic                          vld1;
  logic signed [COEF_W-1:0]      a1;
  logic signed [COEF_W-1:0]      b1;
  logic signed [2*COEF_W-1:0]    bb1;
  logic signed [2*COEF_W-1:0]    ac1;

  logic signed [DISC_W-1:0]      disc;
  logic [CNT_W-1:0]              count;
  logic [COEF_W-1:0]             a_abs;
  logic signed [COEF_W:0]        negb;
  side_t                         side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
    if (en) begin
      a1  <= in_a;
      b1  <= in_b;
      bb1 <= in_b * in_b;
      ac1 <= in_a * in_c;
    end
  end

  assign disc  = DISC_W'(bb1) - (DISC_W'(ac1) <<< 2);
  assign a_abs = a1[COEF_W-1] ? COEF_W'(-a1) : COEF_W'(a1);
  assign negb  = -(COEF_W+1)'(b1);

  always_comb begin
    priority if (a1 == '0) begin
      count = CNT_NONE;
    end else if (disc[DISC_W-1]) begin
      count = CNT_NONE;
    end else if (disc == '0) begin
      count = CNT_ONE;
    end else begin
      count = CNT_TWO;
    end
    side_next.count   = count;
    side_next.b_pos   = !b1[COEF_W-1] && (b1 != '0);
    side_next.nb      = {negb, {FRAC_W{1'b0}}};
    side_next.den_neg = a1[COEF_W-1];
    side_next.den_mag = {a_abs, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld1;
    end
    if (en) begin
      // drop a negative discriminant (or a zero a) to zero so the root stages stay tame
      out_rad  <= (count == CNT_NONE) ? '0 : disc[RAD_W-1:0];
      out_side <= side_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/qrs_sqrt.sv =====
// Pipelined digit-by-digit square root, one root bit per stage, with the
// item sideband carried alongside. Depends on qrs_pkg.
`default_nettype none
module qrs_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [qrs_pkg::RAD_W-1:0]   in_rad,
  input  qrs_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [qrs_pkg::ROOT_W-1:0]  out_root,
  output qrs_pkg::side_t              out_side
);
  import qrs_pkg::*;

  logic              vld_q  [SQ_STEPS];
  logic [RAD_W-1:0]  rad_q  [SQ_STEPS];
  logic [REM_W-1:0]  rem_q  [SQ_STEPS];
  logic [ROOT_W-1:0] root_q [SQ_STEPS];
  side_t             side_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic                  vld_in;
    logic [RAD_W-1:0]      rad_in;
    logic [REM_W-1:0]      rem_in;
    logic [ROOT_W-1:0]     root_in;
    side_t                 side_in;
    logic [2*SQ_STEPS-1:0] radicand;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  fits;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign radicand = {{(2*SQ_STEPS-RAD_W-2*FRAC_W){1'b0}}, rad_in, {(2*FRAC_W){1'b0}}};
    assign rem_sh   = {rem_in[REM_W-3:0], radicand[2*SQ_STEPS-1-2*k -: 2]};
    assign trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
    assign fits     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
      if (en) begin
        rad_q[k]  <= rad_in;
        side_q[k] <= side_in;
        rem_q[k]  <= fits ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], fits};
      end
    end
  end

  assign out_vld  = vld_q[SQ_STEPS-1];
  assign out_root = root_q[SQ_STEPS-1];
  assign out_side = side_q[SQ_STEPS-1];
endmodule
`default_nettype wire

// ===== hw/rtl/qrs_div.sv =====
// Numerator forming plus two pipelined restoring dividers (near and far
// roots), one quotient bit per stage. Depends on qrs_pkg.
`default_nettype none
module qrs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [qrs_pkg::ROOT_W-1:0]  in_root,
  input  qrs_pkg::side_t              in_side,
  output logic                        out_vld,
  output qrs_pkg::quo_t               out_quo
);
  import qrs_pkg::*;

  logic signed [NUM_W-1:0] s_ext;
  logic signed [NUM_W-1:0] nb_ext;
  logic signed [NUM_W-1:0] num_next [2];

  logic             pre_vld;
  logic [MAG_W-1:0] pre_mag [2];
  logic             pre_neg [2];
  logic [CNT_W-1:0] pre_cnt;
  logic [DEN_W-1:0] pre_den;

  assign s_ext  = NUM_W'(in_root);
  assign nb_ext = NUM_W'(in_side.nb);
  // the root whose sign follows b is the one of smaller magnitude
  assign num_next[0] = in_side.b_pos ? nb_ext + s_ext : nb_ext - s_ext;
  assign num_next[1] = in_side.b_pos ? nb_ext - s_ext : nb_ext + s_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else if (en) begin
      pre_vld <= in_vld;
    end
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        pre_mag[l] <= num_next[l][NUM_W-1] ? MAG_W'(-num_next[l]) : MAG_W'(num_next[l]);
        pre_neg[l] <= num_next[l][NUM_W-1] ^ in_side.den_neg;
      end
      pre_cnt <= in_side.count;
      pre_den <= in_side.den_mag;
    end
  end

  logic              vld_q [DIV_STEPS];
  logic [CNT_W-1:0]  cnt_q [DIV_STEPS];
  logic [DEN_W-1:0]  den_q [DIV_STEPS];
  logic              neg_q [DIV_STEPS][2];
  logic [MAG_W-1:0]  mag_q [DIV_STEPS][2];
  logic [DREM_W-1:0] rem_q [DIV_STEPS][2];
  logic [MAG_W-1:0]  quo_q [DIV_STEPS][2];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic             vld_in;
    logic [CNT_W-1:0] cnt_in;
    logic [DEN_W-1:0] den_in;

    if (k == 0) begin : g_first
      assign vld_in = pre_vld;
      assign cnt_in = pre_cnt;
      assign den_in = pre_den;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign cnt_in = cnt_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
      if (en) begin
        cnt_q[k] <= cnt_in;
        den_q[k] <= den_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic              neg_in;
      logic [MAG_W-1:0]  mag_in;
      logic [DREM_W-1:0] rem_in;
      logic [MAG_W-1:0]  quo_in;
      logic [DREM_W-1:0] rem_sh;
      logic              ge;

      if (k == 0) begin : g_first
        assign neg_in = pre_neg[l];
        assign mag_in = pre_mag[l];
        assign rem_in = '0;
        assign quo_in = '0;
      end else begin : g_next
        assign neg_in = neg_q[k-1][l];
        assign mag_in = mag_q[k-1][l];
        assign rem_in = rem_q[k-1][l];
        assign quo_in = quo_q[k-1][l];
      end

      assign rem_sh = {rem_in[DREM_W-2:0], mag_in[MAG_W-1-k]};
      assign ge     = rem_sh >= {1'b0, den_in};

      always_ff @(posedge clk) begin
        if (en) begin
          neg_q[k][l] <= neg_in;
          mag_q[k][l] <= mag_in;
          rem_q[k][l] <= ge ? rem_sh - {1'b0, den_in} : rem_sh;
          quo_q[k][l] <= {quo_in[MAG_W-2:0], ge};
        end
      end
    end
  end

  assign out_vld           = vld_q[DIV_STEPS-1];
  assign out_quo.count     = cnt_q[DIV_STEPS-1];
  assign out_quo.near_neg  = neg_q[DIV_STEPS-1][0];
  assign out_quo.far_neg   = neg_q[DIV_STEPS-1][1];
  assign out_quo.near_mag  = quo_q[DIV_STEPS-1][0];
  assign out_quo.far_mag   = quo_q[DIV_STEPS-1][1];
endmodule
`default_nettype wire

// ===== hw/rtl/quadratic_root_solver_unit.sv =====
// Quadratic root solver top level: real roots of a*x^2 + b*x + c in Q16.16.
// Pipeline stages: 2 discriminant, 33 square root, 1 numerator,
// 34 divider and 1 output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous) clears every stage valid bit; no clearing pass.
// Depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module quadratic_root_solver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // coef_a[15:0], coef_b[31:16], coef_c[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // root_count[1:0], root_near[33:2],
                                      // root_far[65:34], saturated[66], zero pad
);
  import qrs_pkg::*;

  // Advance every stage when the output register is empty or being taken.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic              fr_vld;
  logic [RAD_W-1:0]  fr_rad;
  side_t             fr_side;
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;
  logic              dv_vld;
  quo_t              dv_quo;

  qrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_axis_tvalid),
    .in_a     (s_axis_tdata[15:0]),
    .in_b     (s_axis_tdata[31:16]),
    .in_c     (s_axis_tdata[47:32]),
    .out_vld  (fr_vld),
    .out_rad  (fr_rad),
    .out_side (fr_side)
  );

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (fr_vld),
    .in_rad   (fr_rad),
    .in_side  (fr_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  qrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (sq_vld),
    .in_root  (sq_root),
    .in_side  (sq_side),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo)
  );

  // Clip a sign-magnitude quotient to the signed 32-bit range.
  function automatic logic [OUT_W:0] clip(input logic neg, input logic [MAG_W-1:0] mag);
    logic over;
    logic [OUT_W-1:0] val;
    if (neg) begin
      over = (mag[MAG_W-1:OUT_W] != '0) || (mag[OUT_W-1] && (mag[OUT_W-2:0] != '0));
      val  = over ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-mag[OUT_W-1:0]);
    end else begin
      over = (mag[MAG_W-1:OUT_W-1] != '0);
      val  = over ? {1'b0, {(OUT_W-1){1'b1}}} : mag[OUT_W-1:0];
    end
    return {over, val};
  endfunction

  logic [OUT_W:0]   near_c;
  logic [OUT_W:0]   far_c;
  logic             has_near;
  logic             has_far;
  logic [CNT_W-1:0] root_count;
  logic [OUT_W-1:0] root_near;
  logic [OUT_W-1:0] root_far;
  logic             saturated;

  assign near_c   = clip(dv_quo.near_neg, dv_quo.near_mag);
  assign far_c    = clip(dv_quo.far_neg, dv_quo.far_mag);
  assign has_near = dv_quo.count != CNT_NONE;
  assign has_far  = dv_quo.count == CNT_TWO;

  // Output register: hold while the sink stalls, drop unused roots to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_vld;
    end
    if (en) begin
      root_count <= dv_quo.count;
      root_near  <= has_near ? near_c[OUT_W-1:0] : '0;
      root_far   <= has_far ? far_c[OUT_W-1:0] : '0;
      saturated  <= (has_near && near_c[OUT_W]) || (has_far && far_c[OUT_W]);
    end
  end

  assign m_axis_tdata = {5'b0, saturated, root_far, root_near, root_count};

  `QRS_ASSERT_IMPL(a_count_legal, clk, rst, m_axis_tvalid, root_count != 2'd3, "root count out of range")
  `QRS_ASSERT_IMPL(a_sat_needs_root, clk, rst, m_axis_tvalid && saturated, root_count != CNT_NONE, "saturated with no root")
  `QRS_ASSERT_IMPL(a_far_unused_zero, clk, rst, m_axis_tvalid && root_count != CNT_TWO, root_far == '0, "far root set without two roots")
  `QRS_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(root_near) && $stable(root_count), "result changed under stall")
endmodule
`default_nettype wire
